// ===== src/hsvca_pkg.sv =====
// ---------------------------------------------------------------------------
// HSV color adjust package
// Shared constants, register indexes and types of the HSV color adjust block.
// ---------------------------------------------------------------------------
`default_nettype none

package hsvca_pkg;

  localparam int unsigned CompW      = 16;
  localparam int unsigned HueFull    = 23040;
  localparam int unsigned HueSector  = 3840;
  localparam int unsigned OneQ14     = 16384;
  localparam int unsigned MaxNarrow  = 'hff;
  localparam int unsigned MaxWide    = 'hffff;

  localparam int unsigned DivDenW    = 16;
  localparam int unsigned DivQuoW    = 15;

  localparam logic [25:0] XFULL      = 26'd62914560;
  localparam logic [55:0] ROUND_HALF = 56'd15 << 35;
  localparam logic [20:0] RECIP15    = 21'd1118482;
  localparam int unsigned RecipShift = 24;

  localparam logic [1:0] REG_HUE_OFFSET      = 2'd0;
  localparam logic [1:0] REG_SATURATION_GAIN = 2'd1;
  localparam logic [1:0] REG_VALUE_GAIN      = 2'd2;
  localparam logic [1:0] REG_WIDE_COMPONENTS = 2'd3;

  localparam logic [1:0] MAX_IS_RED   = 2'd0;
  localparam logic [1:0] MAX_IS_GREEN = 2'd1;
  localparam logic [1:0] MAX_IS_BLUE  = 2'd2;

  localparam int unsigned LANE_V = 0;
  localparam int unsigned LANE_P = 1;
  localparam int unsigned LANE_Q = 2;
  localparam int unsigned LANE_T = 3;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic        bypass;
  } side_t;

  typedef struct packed {
    side_t      side;
    logic       delta_zero;
    logic [1:0] max_sel;
  } div_side_t;

endpackage

`default_nettype wire

// ===== src/hsv_color_adjust.sv =====
// ---------------------------------------------------------------------------
// HSV color adjust
// Converts an RGBA pixel to HSV, shifts hue, scales saturation and value,
// and converts back to RGB. Alpha is passed through.
// ---------------------------------------------------------------------------
// Usage: pixels enter on the in_ channel (valid/stall) and leave on the out_
// channel. One transaction carries red, green, blue and alpha components.
// The APB port holds hue offset, saturation gain, value gain and component
// width; the user must write it only while no pixel is in flight; the block
// itself does not enforce this. Throughput is one pixel per cycle while the
// output is not stalled, set by the fully pipelined datapath: a
// 15-stage divider for value, saturation and hue, then hue wrap and gains,
// sector split, hexcone terms, products, scaling and reciprocal rounding.
// When the receiver stalls a valid output, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the identity settings, under which
// color components are passed through, masked to the component width.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_color_adjust (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_red_in,
  input  wire logic [15:0] in_green_in,
  input  wire logic [15:0] in_blue_in,
  input  wire logic [15:0] in_alpha_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] out_red_out,
  output logic      [15:0] out_green_out,
  output logic      [15:0] out_blue_out,
  output logic      [15:0] out_alpha_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  import hsvca_pkg::*;

  localparam int unsigned DivLat = DivQuoW;

  logic [14:0] hue_offset_r;
  logic [15:0] sat_gain_r;
  logic [15:0] val_gain_r;
  logic        wide_r;
  logic        adv;
  logic [15:0] cmax;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_offset_r <= '0;
      sat_gain_r   <= 16'(OneQ14);
      val_gain_r   <= 16'(OneQ14);
      wide_r       <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_HUE_OFFSET:      hue_offset_r <= pwdata[14:0];
        REG_SATURATION_GAIN: sat_gain_r   <= pwdata[15:0];
        REG_VALUE_GAIN:      val_gain_r   <= pwdata[15:0];
        REG_WIDE_COMPONENTS: wide_r       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HUE_OFFSET:      prdata = {17'd0, hue_offset_r};
      REG_SATURATION_GAIN: prdata = {16'd0, sat_gain_r};
      REG_VALUE_GAIN:      prdata = {16'd0, val_gain_r};
      REG_WIDE_COMPONENTS: prdata = {31'd0, wide_r};
      default:             prdata = '0;
    endcase
  end

  assign cmax     = wide_r ? 16'(MaxWide) : 16'(MaxNarrow);
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage A: masking, max and min, hue numerator term.
  logic [15:0] r_m, g_m, b_m, hi, lo, pos, neg;
  logic [1:0]  max_sel;
  logic        va_r;
  div_side_t   a_side_r;
  logic [15:0] a_hi_r, a_delta_r;
  logic [16:0] a_x_r;

  always_comb begin
    r_m = in_red_in & cmax;
    g_m = in_green_in & cmax;
    b_m = in_blue_in & cmax;
    hi  = (r_m > g_m) ? r_m : g_m;
    if (b_m > hi) begin
      hi = b_m;
    end
    lo  = (r_m < g_m) ? r_m : g_m;
    if (b_m < lo) begin
      lo = b_m;
    end
    if (r_m == hi) begin
      max_sel = MAX_IS_RED;
      pos = g_m;
      neg = b_m;
    end else if (g_m == hi) begin
      max_sel = MAX_IS_GREEN;
      pos = b_m;
      neg = r_m;
    end else begin
      max_sel = MAX_IS_BLUE;
      pos = r_m;
      neg = g_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_hi_r                <= hi;
      a_delta_r             <= hi - lo;
      a_x_r                 <= {1'b0, pos} + {1'b0, hi - lo} - {1'b0, neg};
      a_side_r.max_sel      <= max_sel;
      a_side_r.delta_zero   <= (hi == lo);
      a_side_r.side.red     <= r_m;
      a_side_r.side.green   <= g_m;
      a_side_r.side.blue    <= b_m;
      a_side_r.side.alpha   <= in_alpha_in;
      a_side_r.side.bypass  <= (hue_offset_r == '0) && (sat_gain_r == 16'(OneQ14)) &&
                               (val_gain_r == 16'(OneQ14));
    end
  end

  // Divider stages for value, saturation and hue fraction.
  logic [30:0] num_v, num_s, num_q;
  logic [14:0] quo_v, quo_s, quo_q;

  assign num_v = {1'b0, a_hi_r, 14'd0} + {16'd0, cmax[15:1]};
  assign num_s = {1'b0, a_delta_r, 14'd0} + {16'd0, a_hi_r[15:1]};
  assign num_q = {2'd0, a_x_r, 12'd0} - {6'd0, a_x_r, 8'd0} + {16'd0, a_delta_r[15:1]};

  hsvca_div #(.DW(DivDenW), .QW(DivQuoW)) u_div_v (
    .clk(clk), .en(adv), .num(num_v), .den(cmax), .quo(quo_v)
  );
  hsvca_div #(.DW(DivDenW), .QW(DivQuoW)) u_div_s (
    .clk(clk), .en(adv), .num(num_s), .den(a_hi_r), .quo(quo_s)
  );
  hsvca_div #(.DW(DivDenW), .QW(DivQuoW)) u_div_q (
    .clk(clk), .en(adv), .num(num_q), .den(a_delta_r), .quo(quo_q)
  );

  logic      dv_r   [DivLat];
  div_side_t dside_r[DivLat];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DivLat; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else if (adv) begin
      dv_r[0] <= va_r;
      for (int i = 1; i < DivLat; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dside_r[0] <= a_side_r;
      for (int i = 1; i < DivLat; i++) begin
        dside_r[i] <= dside_r[i-1];
      end
    end
  end

  // Stage C: hue assembly and wrap, gains.
  div_side_t   dend;
  logic signed [17:0] h0, h1, h2;
  logic [14:0] s_raw;
  logic [30:0] s_prod, v_prod;
  logic [16:0] s_sh, v_sh;
  logic        vc_r;
  side_t       c_side_r;
  logic [14:0] c_h_r, c_s_r, c_v_r;

  assign dend = dside_r[DivLat-1];

  always_comb begin
    case (dend.max_sel)
      MAX_IS_GREEN: h0 = 18'sd7680;
      MAX_IS_BLUE:  h0 = 18'sd15360;
      default:      h0 = 18'sd0;
    endcase
    h0 = h0 + $signed({3'd0, quo_q}) - 18'sd3840;
    if (h0 < 0) begin
      h0 = h0 + 18'sd23040;
    end
    if (dend.delta_zero) begin
      h0 = '0;
    end
    h1 = h0 + {{3{hue_offset_r[14]}}, hue_offset_r};
    if (h1 >= 18'sd23040) begin
      h1 = h1 - 18'sd23040;
    end
    h2 = h1;
    if (h2 < 0) begin
      h2 = h2 + 18'sd23040;
    end
    s_raw  = dend.delta_zero ? 15'd0 : quo_s;
    s_prod = 31'(s_raw * sat_gain_r) + 31'd8192;
    v_prod = 31'(quo_v * val_gain_r) + 31'd8192;
    s_sh   = s_prod[30:14];
    v_sh   = v_prod[30:14];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= dv_r[DivLat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_side_r <= dend.side;
      c_h_r    <= h2[14:0];
      c_s_r    <= (s_sh > 17'(OneQ14)) ? 15'(OneQ14) : s_sh[14:0];
      c_v_r    <= (v_sh > 17'(OneQ14)) ? 15'(OneQ14) : v_sh[14:0];
    end
  end

  // Stage D1: sector and position inside the sector.
  logic [2:0]  sector;
  logic [14:0] sec_base;
  logic        vd1_r;
  side_t       d1_side_r;
  logic [2:0]  d1_sector_r;
  logic [11:0] d1_f_r;
  logic [14:0] d1_s_r, d1_v_r;

  always_comb begin
    if (c_h_r < 15'd3840) begin
      sector = 3'd0;
    end else if (c_h_r < 15'd7680) begin
      sector = 3'd1;
    end else if (c_h_r < 15'd11520) begin
      sector = 3'd2;
    end else if (c_h_r < 15'd15360) begin
      sector = 3'd3;
    end else if (c_h_r < 15'd19200) begin
      sector = 3'd4;
    end else begin
      sector = 3'd5;
    end
    case (sector)
      3'd0:    sec_base = 15'd0;
      3'd1:    sec_base = 15'd3840;
      3'd2:    sec_base = 15'd7680;
      3'd3:    sec_base = 15'd11520;
      3'd4:    sec_base = 15'd15360;
      default: sec_base = 15'd19200;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd1_r <= 1'b0;
    end else if (adv) begin
      vd1_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_side_r   <= c_side_r;
      d1_sector_r <= sector;
      d1_f_r      <= 12'(c_h_r - sec_base);
      d1_s_r      <= c_s_r;
      d1_v_r      <= c_v_r;
    end
  end

  // Stage D2: hexcone terms.
  logic [14:0] one_minus_s;
  logic [11:0] f_rev;
  logic        vd2_r;
  side_t       d2_side_r;
  logic [2:0]  d2_sector_r;
  logic [14:0] d2_v_r;
  logic [25:0] d2_x_r [4];

  assign one_minus_s = 15'(OneQ14) - d1_s_r;
  assign f_rev       = 12'(HueSector) - d1_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd2_r <= 1'b0;
    end else if (adv) begin
      vd2_r <= vd1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_side_r      <= d1_side_r;
      d2_sector_r    <= d1_sector_r;
      d2_v_r         <= d1_v_r;
      d2_x_r[LANE_V] <= XFULL;
      d2_x_r[LANE_P] <= {one_minus_s, 11'd0} + {one_minus_s, 10'd0} +
                        {one_minus_s, 9'd0} + {one_minus_s, 8'd0};
      d2_x_r[LANE_Q] <= XFULL - 26'(d1_s_r * d1_f_r);
      d2_x_r[LANE_T] <= XFULL - 26'(d1_s_r * f_rev);
    end
  end

  // Stage E: value times hexcone term.
  logic        ve_r;
  side_t       e_side_r;
  logic [2:0]  e_sector_r;
  logic [39:0] e_p_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv) begin
      ve_r <= vd2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_side_r   <= d2_side_r;
      e_sector_r <= d2_sector_r;
      for (int i = 0; i < 4; i++) begin
        e_p_r[i] <= 40'(d2_v_r * d2_x_r[i]);
      end
    end
  end

  // Stage F: scale by component maximum, round, drop the power-of-two part.
  logic [55:0] scaled [4];
  logic        vf_r;
  side_t       f_side_r;
  logic [2:0]  f_sector_r;
  logic [19:0] f_n_r [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (wide_r) begin
        scaled[i] = {e_p_r[i], 16'd0} - {16'd0, e_p_r[i]} + ROUND_HALF;
      end else begin
        scaled[i] = {8'd0, e_p_r[i], 8'd0} - {16'd0, e_p_r[i]} + ROUND_HALF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (adv) begin
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_side_r   <= e_side_r;
      f_sector_r <= e_sector_r;
      for (int i = 0; i < 4; i++) begin
        f_n_r[i] <= scaled[i][55:36];
      end
    end
  end

  // Stage G: division by fifteen through the reciprocal.
  logic        vg_r;
  side_t       g_side_r;
  logic [2:0]  g_sector_r;
  logic [40:0] g_m_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (adv) begin
      vg_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_side_r   <= f_side_r;
      g_sector_r <= f_sector_r;
      for (int i = 0; i < 4; i++) begin
        g_m_r[i] <= 41'(f_n_r[i] * RECIP15);
      end
    end
  end

  // Output stage: clip, sector routing, bypass.
  logic [16:0] cq17 [4];
  logic [15:0] comp [4];
  logic [15:0] red_nxt, green_nxt, blue_nxt;
  logic        out_valid_r;
  logic [15:0] red_r, green_r, blue_r, alpha_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cq17[i] = g_m_r[i][40:RecipShift];
      comp[i] = (cq17[i] > {1'b0, cmax}) ? cmax : cq17[i][15:0];
    end
    case (g_sector_r)
      3'd0: begin
        red_nxt = comp[LANE_V]; green_nxt = comp[LANE_T]; blue_nxt = comp[LANE_P];
      end
      3'd1: begin
        red_nxt = comp[LANE_Q]; green_nxt = comp[LANE_V]; blue_nxt = comp[LANE_P];
      end
      3'd2: begin
        red_nxt = comp[LANE_P]; green_nxt = comp[LANE_V]; blue_nxt = comp[LANE_T];
      end
      3'd3: begin
        red_nxt = comp[LANE_P]; green_nxt = comp[LANE_Q]; blue_nxt = comp[LANE_V];
      end
      3'd4: begin
        red_nxt = comp[LANE_T]; green_nxt = comp[LANE_P]; blue_nxt = comp[LANE_V];
      end
      default: begin
        red_nxt = comp[LANE_V]; green_nxt = comp[LANE_P]; blue_nxt = comp[LANE_Q];
      end
    endcase
    if (g_side_r.bypass) begin
      red_nxt   = g_side_r.red;
      green_nxt = g_side_r.green;
      blue_nxt  = g_side_r.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= g_side_r.alpha;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;
  assign out_alpha_out = alpha_r;

  a_out_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (red_r <= cmax && green_r <= cmax && blue_r <= cmax))
    else $error("Output component exceeds the component maximum.");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r |-> c_h_r < 15'(HueFull))
    else $error("Wrapped hue is out of range.");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    vd1_r |-> (d1_f_r < 12'(HueSector) && d1_s_r <= 15'(OneQ14)))
    else $error("Sector position or saturation is out of range.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(vg_r) && $stable(red_nxt))
    else $error("Pipeline moved while the output was stalled.");

endmodule

`default_nettype wire

// ===== src/hsvca_div.sv =====
// ---------------------------------------------------------------------------
// HSV color adjust divider
// Pipelined restoring divider that resolves one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module hsvca_div #(
  parameter int unsigned DW = hsvca_pkg::DivDenW,
  parameter int unsigned QW = hsvca_pkg::DivQuoW
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW+QW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] quo
);

  logic [DW-1:0] rem_in  [QW];
  logic [QW-1:0] low_in  [QW];
  logic [DW-1:0] den_in  [QW];
  logic [QW-1:0] quo_in  [QW];
  logic [DW-1:0] rem_r   [QW];
  logic [QW-1:0] low_r   [QW];
  logic [DW-1:0] den_r   [QW];
  logic [QW-1:0] quo_r   [QW];

  assign rem_in[0] = num[DW+QW-1:QW];
  assign low_in[0] = num[QW-1:0];
  assign den_in[0] = den;
  assign quo_in[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    if (k > 0) begin : g_link
      assign rem_in[k] = rem_r[k-1];
      assign low_in[k] = low_r[k-1];
      assign den_in[k] = den_r[k-1];
      assign quo_in[k] = quo_r[k-1];
    end

    always_comb begin
      trial   = {rem_in[k], low_in[k][QW-1]};
      diff    = trial - {1'b0, den_in[k]};
      ge      = (trial >= {1'b0, den_in[k]});
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= {low_in[k][QW-2:0], 1'b0};
        den_r[k] <= den_in[k];
        quo_r[k] <= {quo_in[k][QW-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

`default_nettype wire
